### rtl/core/dfg_pkg.sv
// ----------------------------------------------------------------------------
// dfg_pkg
// Shared types and constants of the DShot frame generator.
// ----------------------------------------------------------------------------
package dfg_pkg;

  localparam int FRAME_BITS  = 16;
  localparam int TRAIL_WORDS = 2;
  localparam int SLOTS       = FRAME_BITS + TRAIL_WORDS;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int BIT_IDX_W   = $clog2(FRAME_BITS);

  localparam int VALUE_W     = 11;
  localparam int CODE_W      = 6;
  localparam int REPS_W      = 4;
  localparam int DUTY_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_THROTTLE = 2'd1;
  localparam logic [1:0] OP_COMMAND  = 2'd2;
  localparam logic [1:0] OP_STOP     = 2'd3;

  // result kinds
  localparam logic KIND_DUTY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_THROTTLE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_THROTTLE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ONE_BIT_DUTY    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BIT_DUTY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_ONLY_LIMIT = 3'd4;

  // register reset values
  localparam logic [VALUE_W-1:0] MIN_THROTTLE_RST    = 11'd48;
  localparam logic [VALUE_W-1:0] MAX_THROTTLE_RST    = 11'd2047;
  localparam logic [DUTY_W-1:0]  ONE_BIT_DUTY_RST    = 16'd30;
  localparam logic [DUTY_W-1:0]  ZERO_BIT_DUTY_RST   = 16'd15;
  localparam logic [CODE_W-1:0]  STOP_ONLY_LIMIT_RST = 6'd36;

  typedef struct packed {
    logic [1:0]        op;
    logic [15:0]       throttle;
    logic [CODE_W-1:0] command_code;
    logic [REPS_W-1:0] repeat_count;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [DUTY_W-1:0] duty;
    logic              accepted;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] min_throttle;
    logic [VALUE_W-1:0] max_throttle;
    logic [DUTY_W-1:0]  one_bit_duty;
    logic [DUTY_W-1:0]  zero_bit_duty;
    logic [CODE_W-1:0]  stop_only_limit;
  } cfg_t;

  // work handed from front to back
  typedef struct packed {
    logic                  is_status;
    logic                  accepted;
    logic [FRAME_BITS-1:0] frame;
  } job_t;

  // 11-bit value, zero telemetry bit, nibble-XOR checksum
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [VALUE_W-1:0] value);
    logic [11:0] word;
    logic [3:0]  sum;
    word = {value, 1'b0};
    sum  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, sum};
  endfunction

endpackage

### rtl/core/dfg_front.sv
// ----------------------------------------------------------------------------
// dfg_front
// Accepts items, keeps throttle and pending command, and queues frame and
// status jobs for the back end.
// ----------------------------------------------------------------------------
module dfg_front (
  input  logic            clk,
  input  logic            rst,
  input  dfg_pkg::cfg_t   cfg,
  input  logic            push,
  input  dfg_pkg::in_item_t item,
  input  logic            job_full,
  output logic            job_push,
  output dfg_pkg::job_t   job
);
  import dfg_pkg::*;

  logic [VALUE_W-1:0] throttle_level, throttle_level_next;
  logic [CODE_W-1:0]  pending_command, pending_command_next;
  logic [REPS_W-1:0]  pending_repeats, pending_repeats_next;

  logic               take;
  logic [15:0]        min_ext, max_ext, clamped;
  logic               refused;
  logic [VALUE_W-1:0] send_value;

  assign take    = push && !job_full;
  assign min_ext = {5'd0, cfg.min_throttle};
  assign max_ext = {5'd0, cfg.max_throttle};
  assign refused = (item.command_code <= cfg.stop_only_limit) && (throttle_level != '0);

  always_comb begin
    if (item.throttle < min_ext) begin
      clamped = min_ext;
    end else if (item.throttle > max_ext) begin
      clamped = max_ext;
    end else begin
      clamped = item.throttle;
    end
  end

  assign send_value = (pending_repeats != '0) ? VALUE_W'(pending_command) : throttle_level;

  always_comb begin
    throttle_level_next  = throttle_level;
    pending_command_next = pending_command;
    pending_repeats_next = pending_repeats;
    job_push             = 1'b0;
    job                  = '0;
    if (take) begin
      case (item.op)
        OP_TICK: begin
          job_push  = 1'b1;
          job.frame = build_frame(send_value);
          if (pending_repeats != '0) begin
            pending_repeats_next = pending_repeats - 1'b1;
          end
        end
        OP_THROTTLE: begin
          // max below min leaves the clamped value at or under min: level is zero
          if (clamped >= min_ext) begin
            throttle_level_next = VALUE_W'(clamped - min_ext);
          end else begin
            throttle_level_next = '0;
          end
        end
        OP_COMMAND: begin
          job_push             = 1'b1;
          job.is_status        = 1'b1;
          job.accepted         = !refused;
          pending_command_next = item.command_code;
          if (!refused) begin
            pending_repeats_next = item.repeat_count;
          end
        end
        OP_STOP: begin
          throttle_level_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_level  <= '0;
      pending_command <= '0;
      pending_repeats <= '0;
    end else begin
      throttle_level  <= throttle_level_next;
      pending_command <= pending_command_next;
      pending_repeats <= pending_repeats_next;
    end
  end

endmodule

### rtl/core/dfg_queue.sv
// ----------------------------------------------------------------------------
// dfg_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module dfg_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  dfg_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output dfg_pkg::job_t rd_job,
  output logic          empty
);
  import dfg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/dfg_back.sv
// ----------------------------------------------------------------------------
// dfg_back
// Serialises queued jobs into duty words and status results through an
// output register.
// ----------------------------------------------------------------------------
module dfg_back (
  input  logic              clk,
  input  logic              rst,
  input  dfg_pkg::cfg_t     cfg,
  input  logic              job_empty,
  input  dfg_pkg::job_t     job,
  output logic              job_pop,
  output dfg_pkg::out_item_t result,
  output logic              empty,
  input  logic              pop
);
  import dfg_pkg::*;

  logic                 out_valid;
  out_item_t            out_q, out_next;
  logic [SLOT_W-1:0]    slot;
  logic                 load;
  logic                 last_slot;
  logic [BIT_IDX_W-1:0] bit_idx;

  assign load      = !job_empty && (!out_valid || pop);
  assign last_slot = (slot == SLOT_W'(SLOTS - 1));
  assign bit_idx   = BIT_IDX_W'(FRAME_BITS - 1) - slot[BIT_IDX_W-1:0];
  assign job_pop   = load && (job.is_status || last_slot);
  assign empty     = !out_valid;
  assign result    = out_q;

  always_comb begin
    out_next = '0;
    if (job.is_status) begin
      out_next.kind     = KIND_STATUS;
      out_next.accepted = job.accepted;
      out_next.last     = 1'b1;
    end else begin
      out_next.kind = KIND_DUTY;
      if (slot < SLOT_W'(FRAME_BITS)) begin
        out_next.duty = job.frame[bit_idx] ? cfg.one_bit_duty : cfg.zero_bit_duty;
      end
      out_next.last = last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (!job.is_status) begin
          slot <= last_slot ? '0 : slot + 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/dshot_frame_generator.sv
// Path: an item's job is written to the job queue and its result then to the
// output register. Throughput: one item per cycle in while not full; one result
// word per cycle out while pop is held; a tick yields 18 words, a command one.
// The job queue (QUEUE_DEPTH entries) plus the output register absorb bursts.
// Reset: throttle, pending command and repeat count clear; registers reload.
// ----------------------------------------------------------------------------
// dshot_frame_generator
// DShot frame encoder: throttle and special command handling, frame build
// and per-bit duty word output.
// ----------------------------------------------------------------------------
module dshot_frame_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  dfg_pkg::in_item_t                   item,
  output logic                                empty,
  input  logic                                pop,
  output dfg_pkg::out_item_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dfg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dfg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dfg_pkg::*;

  cfg_t cfg;
  logic job_push, job_full, job_pop, job_empty;
  job_t wr_job, rd_job;

  assign cfg_ready = 1'b1;
  assign full      = job_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_throttle    <= MIN_THROTTLE_RST;
      cfg.max_throttle    <= MAX_THROTTLE_RST;
      cfg.one_bit_duty    <= ONE_BIT_DUTY_RST;
      cfg.zero_bit_duty   <= ZERO_BIT_DUTY_RST;
      cfg.stop_only_limit <= STOP_ONLY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_THROTTLE:    cfg.min_throttle    <= cfg_data[VALUE_W-1:0];
        REG_MAX_THROTTLE:    cfg.max_throttle    <= cfg_data[VALUE_W-1:0];
        REG_ONE_BIT_DUTY:    cfg.one_bit_duty    <= cfg_data[DUTY_W-1:0];
        REG_ZERO_BIT_DUTY:   cfg.zero_bit_duty   <= cfg_data[DUTY_W-1:0];
        REG_STOP_ONLY_LIMIT: cfg.stop_only_limit <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dfg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .item     (item),
    .job_full (job_full),
    .job_push (job_push),
    .job      (wr_job)
  );

  dfg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (wr_job),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_job (rd_job),
    .empty  (job_empty)
  );

  dfg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (rd_job),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
